// File: rtl/tofsc_pkg.sv
// ----------------------------------------------------------------------------
// tofsc_pkg
// Shared widths, fixed-point constants, coefficient tables and pipeline types
// for the time-of-flight slewing correction.
// ----------------------------------------------------------------------------
package tofsc_pkg;

  // Fixed point: times and amplitudes in 2^-FRACTION_BITS ns; the cubics are
  // worked at EXTRA_BITS more fraction bits.
  localparam int FRACTION_BITS = 10;
  localparam int EXTRA_BITS    = 12;
  localparam int CSHIFT        = FRACTION_BITS + EXTRA_BITS;

  localparam int TIME_W   = 32;
  localparam int AMP_IN_W = 16;
  localparam int AMP_W    = AMP_IN_W + 1;   // sum of two strip amplitudes
  localparam int OFF_W    = 18;
  localparam int ABIN_W   = 3;
  localparam int SBIN_W   = 2;

  // one Horner step per coefficient below the cubic term
  localparam int HORNER_STEPS = 3;

  // Horner accumulator. Bin selection limits the amplitude each cubic sees,
  // so the accumulator stays well below 2^(ACC_W-2).
  localparam int ACC_W  = FRACTION_BITS + 26;
  localparam int PROD_W = ACC_W + AMP_W + 1;
  localparam int TOT_W  = 48;

  localparam logic [ABIN_W-1:0] ABIN_LAST      = 3'd4;
  localparam logic [SBIN_W-1:0] START_BIN_LOW  = 2'd0;
  localparam logic [SBIN_W-1:0] START_BIN_HIGH = 2'd1;
  localparam logic [SBIN_W-1:0] START_BIN_NONE = 2'd2;

  // Amplitude thresholds, ns scaled to 2^-FRACTION_BITS and rounded
  localparam logic [31:0] STRIP_THR0 = 32'(((longint'(2046) << FRACTION_BITS) + 50) / 100);
  localparam logic [31:0] STRIP_THR1 = 32'(((longint'(2725) << FRACTION_BITS) + 50) / 100);
  localparam logic [31:0] STRIP_THR2 = 32'(((longint'(3481) << FRACTION_BITS) + 50) / 100);
  localparam logic [31:0] STRIP_THR3 = 32'(((longint'(3711) << FRACTION_BITS) + 50) / 100);
  localparam logic [31:0] START_THR_LO  = 32'(((longint'(615) << FRACTION_BITS) + 50) / 100);
  localparam logic [31:0] START_THR_MID = 32'(((longint'(123) << FRACTION_BITS) + 5) / 10);
  localparam logic [31:0] START_THR_HI  = 32'(((longint'(1714) << FRACTION_BITS) + 50) / 100);

  // Strip cubic coefficients, index is the power of the amplitude
  localparam longint SC0_0 =  (((longint'(1224) << CSHIFT) + 50) / 100);
  localparam longint SC0_1 = -(((longint'(3919) << CSHIFT) + 500) / 1000);
  localparam longint SC0_2 =  (((longint'(2624) << CSHIFT) + 5000) / 10000);
  localparam longint SC0_3 = -(((longint'(5153) << CSHIFT) + 500000) / 1000000);
  localparam longint SC1_0 = -(((longint'(1229) << CSHIFT) + 5) / 10);
  localparam longint SC1_1 =  (((longint'(1484) << CSHIFT) + 50) / 100);
  localparam longint SC1_2 = -(((longint'(6158) << CSHIFT) + 5000) / 10000);
  localparam longint SC1_3 =  (((longint'(8724) << CSHIFT) + 500000) / 1000000);
  localparam longint SC2_0 = -(((longint'(1234) << CSHIFT) + 50) / 100);
  localparam longint SC2_1 =  (((longint'(482) << CSHIFT) + 500) / 1000);
  localparam longint SC3_0 = -(((longint'(1228) << CSHIFT) + 50) / 100);
  localparam longint SC3_1 =  (((longint'(479) << CSHIFT) + 500) / 1000);
  localparam longint SC4_0 = -(((longint'(1314) << CSHIFT) + 50) / 100);
  localparam longint SC4_1 =  (((longint'(5034) << CSHIFT) + 5000) / 10000);

  // Start-counter cubic coefficients
  localparam longint TC0_0 = -(((longint'(5486) << CSHIFT) + 500) / 1000);
  localparam longint TC0_1 =  (((longint'(1087) << CSHIFT) + 500) / 1000);
  localparam longint TC0_2 = -(((longint'(7936) << CSHIFT) + 50000) / 100000);
  localparam longint TC0_3 =  (((longint'(208) << CSHIFT) + 50000) / 100000);
  localparam longint TC1_0 =  (((longint'(1077) << CSHIFT) + 50) / 100);
  localparam longint TC1_1 = -(((longint'(2635) << CSHIFT) + 500) / 1000);
  localparam longint TC1_2 =  (((longint'(1984) << CSHIFT) + 5000) / 10000);
  localparam longint TC1_3 = -(((longint'(4631) << CSHIFT) + 500000) / 1000000);

  localparam longint OFFSET_MAX  = (longint'(1) << (OFF_W - 1)) - 1;
  localparam longint OFFSET_FULL = longint'(14) << FRACTION_BITS;
  localparam logic signed [OFF_W-1:0] OFFSET_RESET =
      (OFFSET_FULL > OFFSET_MAX) ? OFF_W'(OFFSET_MAX) : OFF_W'(OFFSET_FULL);

  localparam logic signed [PROD_W-1:0] PROD_HALF = PROD_W'(longint'(1) << (FRACTION_BITS - 1));
  localparam logic signed [TOT_W-1:0]  TOT_HALF  = TOT_W'(longint'(1) << (EXTRA_BITS - 1));
  localparam logic signed [TOT_W-1:0]  OUT_MAX   = TOT_W'((longint'(1) << (TIME_W - 1)) - 1);
  localparam logic signed [TOT_W-1:0]  OUT_MIN   = TOT_W'(-(longint'(1) << (TIME_W - 1)));

  typedef logic signed [ACC_W-1:0] acc_t;

  // One cubic in flight: accumulator, its amplitude and the coefficients
  // still to add (coef[0] is the next one).
  typedef struct packed {
    acc_t                  acc;
    logic [AMP_W-1:0]      amp;
    logic [2:0][ACC_W-1:0] coef;
  } lane_t;

  typedef struct packed {
    lane_t                    strip;
    lane_t                    start;
    logic signed [TOT_W-1:0]  tbase;
    logic [ABIN_W-1:0]        abin;
    logic [SBIN_W-1:0]        sbin;
  } item_t;

  function automatic acc_t strip_coef(input logic [ABIN_W-1:0] bin, input logic [1:0] k);
    acc_t c;
    c = '0;
    unique case (bin)
      3'd0: begin
        unique case (k)
          2'd0: c = acc_t'(SC0_0);
          2'd1: c = acc_t'(SC0_1);
          2'd2: c = acc_t'(SC0_2);
          default: c = acc_t'(SC0_3);
        endcase
      end
      3'd1: begin
        unique case (k)
          2'd0: c = acc_t'(SC1_0);
          2'd1: c = acc_t'(SC1_1);
          2'd2: c = acc_t'(SC1_2);
          default: c = acc_t'(SC1_3);
        endcase
      end
      3'd2: begin
        unique case (k)
          2'd0: c = acc_t'(SC2_0);
          2'd1: c = acc_t'(SC2_1);
          default: c = '0;
        endcase
      end
      3'd3: begin
        unique case (k)
          2'd0: c = acc_t'(SC3_0);
          2'd1: c = acc_t'(SC3_1);
          default: c = '0;
        endcase
      end
      3'd4: begin
        unique case (k)
          2'd0: c = acc_t'(SC4_0);
          2'd1: c = acc_t'(SC4_1);
          default: c = '0;
        endcase
      end
      default: c = '0;
    endcase
    return c;
  endfunction

  function automatic acc_t start_coef(input logic [SBIN_W-1:0] bin, input logic [1:0] k);
    acc_t c;
    c = '0;
    unique case (bin)
      START_BIN_LOW: begin
        unique case (k)
          2'd0: c = acc_t'(TC0_0);
          2'd1: c = acc_t'(TC0_1);
          2'd2: c = acc_t'(TC0_2);
          default: c = acc_t'(TC0_3);
        endcase
      end
      START_BIN_HIGH: begin
        unique case (k)
          2'd0: c = acc_t'(TC1_0);
          2'd1: c = acc_t'(TC1_1);
          2'd2: c = acc_t'(TC1_2);
          default: c = acc_t'(TC1_3);
        endcase
      end
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

// File: rtl/tofsc_hit_if.sv
// ----------------------------------------------------------------------------
// tofsc_hit_if
// Input channel: one strip hit with its start-counter time per beat.
// ----------------------------------------------------------------------------
interface tofsc_hit_if;
  logic                                         valid;
  logic                                         ready;
  logic signed [tofsc_pkg::TIME_W-1:0]          first_end_time;
  logic signed [tofsc_pkg::TIME_W-1:0]          second_end_time;
  logic        [tofsc_pkg::AMP_IN_W-1:0]        first_end_amplitude;
  logic        [tofsc_pkg::AMP_IN_W-1:0]        second_end_amplitude;
  logic signed [tofsc_pkg::TIME_W-1:0]          start_time;
  logic        [tofsc_pkg::AMP_IN_W-1:0]        start_amplitude;

  modport source (
    output valid, first_end_time, second_end_time, first_end_amplitude,
           second_end_amplitude, start_time, start_amplitude,
    input  ready
  );
  modport sink (
    input  valid, first_end_time, second_end_time, first_end_amplitude,
           second_end_amplitude, start_time, start_amplitude,
    output ready
  );
endinterface

// File: rtl/tofsc_res_if.sv
// ----------------------------------------------------------------------------
// tofsc_res_if
// Output channel: one corrected time of flight with its bins per beat.
// ----------------------------------------------------------------------------
interface tofsc_res_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [tofsc_pkg::TIME_W-1:0]   corrected_flight_time;
  logic        [tofsc_pkg::ABIN_W-1:0]   amplitude_bin;
  logic        [tofsc_pkg::SBIN_W-1:0]   start_bin;

  modport source (
    output valid, corrected_flight_time, amplitude_bin, start_bin,
    input  ready
  );
  modport sink (
    input  valid, corrected_flight_time, amplitude_bin, start_bin,
    output ready
  );
endinterface

// File: rtl/tofsc_front.sv
// ----------------------------------------------------------------------------
// tofsc_front
// Input stage: amplitude sum, bin selection, coefficient load and the
// uncorrected time base.
// ----------------------------------------------------------------------------
module tofsc_front (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  adv_i,
  input  logic                                  valid_i,
  input  logic signed [tofsc_pkg::TIME_W-1:0]   first_end_time_i,
  input  logic signed [tofsc_pkg::TIME_W-1:0]   second_end_time_i,
  input  logic        [tofsc_pkg::AMP_IN_W-1:0] first_end_amplitude_i,
  input  logic        [tofsc_pkg::AMP_IN_W-1:0] second_end_amplitude_i,
  input  logic signed [tofsc_pkg::TIME_W-1:0]   start_time_i,
  input  logic        [tofsc_pkg::AMP_IN_W-1:0] start_amplitude_i,
  output logic                                  valid_o,
  output tofsc_pkg::item_t                      item_o
);

  logic                                 valid_q;
  tofsc_pkg::item_t                     item_d, item_q;
  logic [tofsc_pkg::AMP_W-1:0]          amp_sum;
  logic [31:0]                          amp_sum_w, amp_start_w;
  logic [tofsc_pkg::ABIN_W-1:0]         abin;
  logic [tofsc_pkg::SBIN_W-1:0]         sbin;
  logic signed [tofsc_pkg::TIME_W:0]    tsum;

  assign amp_sum     = {1'b0, first_end_amplitude_i} + {1'b0, second_end_amplitude_i};
  assign amp_sum_w   = 32'(amp_sum);
  assign amp_start_w = 32'(start_amplitude_i);
  assign tsum        = (tofsc_pkg::TIME_W + 1)'(first_end_time_i)
                     + (tofsc_pkg::TIME_W + 1)'(second_end_time_i);

  always_comb begin
    if (amp_sum_w >= tofsc_pkg::STRIP_THR3) begin
      abin = 3'd4;
    end else if (amp_sum_w >= tofsc_pkg::STRIP_THR2) begin
      abin = 3'd3;
    end else if (amp_sum_w >= tofsc_pkg::STRIP_THR1) begin
      abin = 3'd2;
    end else if (amp_sum_w >= tofsc_pkg::STRIP_THR0) begin
      abin = 3'd1;
    end else begin
      abin = 3'd0;
    end

    if (amp_start_w >= tofsc_pkg::START_THR_LO && amp_start_w < tofsc_pkg::START_THR_MID) begin
      sbin = tofsc_pkg::START_BIN_LOW;
    end else if (amp_start_w >= tofsc_pkg::START_THR_MID &&
                 amp_start_w < tofsc_pkg::START_THR_HI) begin
      sbin = tofsc_pkg::START_BIN_HIGH;
    end else begin
      sbin = tofsc_pkg::START_BIN_NONE;
    end
  end

  always_comb begin
    item_d.strip.acc     = tofsc_pkg::strip_coef(abin, 2'd3);
    item_d.strip.amp     = amp_sum;
    item_d.strip.coef[0] = tofsc_pkg::strip_coef(abin, 2'd2);
    item_d.strip.coef[1] = tofsc_pkg::strip_coef(abin, 2'd1);
    item_d.strip.coef[2] = tofsc_pkg::strip_coef(abin, 2'd0);
    item_d.start.acc     = tofsc_pkg::start_coef(sbin, 2'd3);
    item_d.start.amp     = {1'b0, start_amplitude_i};
    item_d.start.coef[0] = tofsc_pkg::start_coef(sbin, 2'd2);
    item_d.start.coef[1] = tofsc_pkg::start_coef(sbin, 2'd1);
    item_d.start.coef[2] = tofsc_pkg::start_coef(sbin, 2'd0);
    // average of the ends minus start, at the fine scale
    item_d.tbase = (tofsc_pkg::TOT_W'(tsum) <<< (tofsc_pkg::EXTRA_BITS - 1))
                 - (tofsc_pkg::TOT_W'(start_time_i) <<< tofsc_pkg::EXTRA_BITS);
    item_d.abin  = abin;
    item_d.sbin  = sbin;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// File: rtl/tofsc_horner_step.sv
// ----------------------------------------------------------------------------
// tofsc_horner_step
// One Horner step for both cubics: multiply stage, then round, add the next
// coefficient and shift the coefficient list.
// ----------------------------------------------------------------------------
module tofsc_horner_step (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             adv_i,
  input  logic             valid_i,
  input  tofsc_pkg::item_t item_i,
  output logic             valid_o,
  output tofsc_pkg::item_t item_o
);

  logic                                 valid_m_q, valid_a_q;
  tofsc_pkg::item_t                     item_m_q, item_a_d, item_a_q;
  logic signed [tofsc_pkg::PROD_W-1:0]  prod_strip_d, prod_strip_q;
  logic signed [tofsc_pkg::PROD_W-1:0]  prod_start_d, prod_start_q;
  logic signed [tofsc_pkg::PROD_W-1:0]  shr_strip, shr_start;
  logic [tofsc_pkg::PROD_W-tofsc_pkg::ACC_W:0] top_strip, top_start;
  logic                                 fits;

  // multiply stage
  assign prod_strip_d = item_i.strip.acc * $signed({1'b0, item_i.strip.amp});
  assign prod_start_d = item_i.start.acc * $signed({1'b0, item_i.start.amp});

  // round to nearest, ties up, then add the next coefficient
  assign shr_strip = (prod_strip_q + tofsc_pkg::PROD_HALF) >>> tofsc_pkg::FRACTION_BITS;
  assign shr_start = (prod_start_q + tofsc_pkg::PROD_HALF) >>> tofsc_pkg::FRACTION_BITS;

  always_comb begin
    item_a_d = item_m_q;
    item_a_d.strip.acc  = tofsc_pkg::acc_t'(shr_strip) + $signed(item_m_q.strip.coef[0]);
    item_a_d.strip.coef = {tofsc_pkg::ACC_W'(0), item_m_q.strip.coef[2], item_m_q.strip.coef[1]};
    item_a_d.start.acc  = tofsc_pkg::acc_t'(shr_start) + $signed(item_m_q.start.coef[0]);
    item_a_d.start.coef = {tofsc_pkg::ACC_W'(0), item_m_q.start.coef[2], item_m_q.start.coef[1]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_m_q <= 1'b0;
      valid_a_q <= 1'b0;
    end else if (adv_i) begin
      valid_m_q <= valid_i;
      valid_a_q <= valid_m_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      item_m_q     <= item_i;
      prod_strip_q <= prod_strip_d;
      prod_start_q <= prod_start_d;
      item_a_q     <= item_a_d;
    end
  end

  assign valid_o = valid_a_q;
  assign item_o  = item_a_q;

  // the rounded product must fit the accumulator without wrap
  assign top_strip = shr_strip[tofsc_pkg::PROD_W-1:tofsc_pkg::ACC_W-1];
  assign top_start = shr_start[tofsc_pkg::PROD_W-1:tofsc_pkg::ACC_W-1];
  assign fits = ((&top_strip) || !(|top_strip)) && ((&top_start) || !(|top_start));

  a_acc_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_m_q |-> fits)
    else $error("Horner product leaves accumulator range");

endmodule

// File: rtl/tofsc_back.sv
// ----------------------------------------------------------------------------
// tofsc_back
// Final sum: time base minus both corrections plus offset, one rounding to
// output units and 32-bit saturation into the output register.
// ----------------------------------------------------------------------------
module tofsc_back (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 adv_i,
  input  logic                                 valid_i,
  input  tofsc_pkg::item_t                     item_i,
  input  logic signed [tofsc_pkg::OFF_W-1:0]   offset_i,
  output logic                                 valid_o,
  output logic signed [tofsc_pkg::TIME_W-1:0]  flight_time_o,
  output logic        [tofsc_pkg::ABIN_W-1:0]  amplitude_bin_o,
  output logic        [tofsc_pkg::SBIN_W-1:0]  start_bin_o
);

  logic                                 valid_b_q, valid_o_q;
  logic signed [tofsc_pkg::TOT_W-1:0]   part_a_d, part_a_q, part_b_d, part_b_q;
  logic        [tofsc_pkg::ABIN_W-1:0]  abin_b_q, abin_o_q;
  logic        [tofsc_pkg::SBIN_W-1:0]  sbin_b_q, sbin_o_q;
  logic signed [tofsc_pkg::TOT_W-1:0]   total, rounded;
  logic signed [tofsc_pkg::TIME_W-1:0]  sat_d, sat_q;

  assign part_a_d = item_i.tbase - tofsc_pkg::TOT_W'(item_i.strip.acc);
  assign part_b_d = (tofsc_pkg::TOT_W'(offset_i) <<< tofsc_pkg::EXTRA_BITS)
                  - tofsc_pkg::TOT_W'(item_i.start.acc);

  assign total   = part_a_q + part_b_q + tofsc_pkg::TOT_HALF;
  assign rounded = total >>> tofsc_pkg::EXTRA_BITS;

  always_comb begin
    if (rounded > tofsc_pkg::OUT_MAX) begin
      sat_d = tofsc_pkg::TIME_W'(tofsc_pkg::OUT_MAX);
    end else if (rounded < tofsc_pkg::OUT_MIN) begin
      sat_d = tofsc_pkg::TIME_W'(tofsc_pkg::OUT_MIN);
    end else begin
      sat_d = tofsc_pkg::TIME_W'(rounded);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_b_q <= 1'b0;
      valid_o_q <= 1'b0;
    end else if (adv_i) begin
      valid_b_q <= valid_i;
      valid_o_q <= valid_b_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      part_a_q <= part_a_d;
      part_b_q <= part_b_d;
      abin_b_q <= item_i.abin;
      sbin_b_q <= item_i.sbin;
      sat_q    <= sat_d;
      abin_o_q <= abin_b_q;
      sbin_o_q <= sbin_b_q;
    end
  end

  assign valid_o         = valid_o_q;
  assign flight_time_o   = sat_q;
  assign amplitude_bin_o = abin_o_q;
  assign start_bin_o     = sbin_o_q;

endmodule

// File: rtl/time_of_flight_slewing_correction.sv
// ----------------------------------------------------------------------------
// time_of_flight_slewing_correction
// Takes one strip hit per beat (two end times and amplitudes, plus the
// start-counter time and amplitude) and returns one slewing corrected time of
// flight per beat. Times are signed, amplitudes unsigned, all in 1/1024 ns.
// The result is the mean of the end times minus the start time, minus a
// cubic in the summed strip amplitude (one of five bins), minus a cubic in
// the start amplitude (one of three bins, the last applies nothing), plus the
// output_offset register (14 ns after reset), rounded and saturated to 32
// bits. The block takes a beat every cycle while the result channel is not
// stalled. Each result passes one input stage, the three Horner steps of the
// cubics at two stages each (multiplier, then round and add), and two stages
// for the final sum and saturation. Backpressure on the result channel stalls
// the whole pipeline; nothing is dropped or repeated. Write output_offset only
// while no beat is in flight.
// ----------------------------------------------------------------------------
module time_of_flight_slewing_correction (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic signed [tofsc_pkg::OFF_W-1:0]  cfg_wdata_i,
  tofsc_hit_if.sink                           hit_i,
  tofsc_res_if.source                         res_o
);

  // pipeline moves when the output register is empty or being drained
  logic                                adv;
  logic signed [tofsc_pkg::OFF_W-1:0]  offset_q;

  logic             stage_valid [0:tofsc_pkg::HORNER_STEPS];
  tofsc_pkg::item_t stage_item  [0:tofsc_pkg::HORNER_STEPS];

  logic                                out_valid;
  logic signed [tofsc_pkg::TIME_W-1:0] out_time;
  logic        [tofsc_pkg::ABIN_W-1:0] out_abin;
  logic        [tofsc_pkg::SBIN_W-1:0] out_sbin;

  assign adv         = !out_valid || res_o.ready;
  assign hit_i.ready = adv;

  // offset register; taken by the final stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= tofsc_pkg::OFFSET_RESET;
    end else if (cfg_we_i) begin
      offset_q <= cfg_wdata_i;
    end
  end

  tofsc_front u_front (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .adv_i                  (adv),
    .valid_i                (hit_i.valid),
    .first_end_time_i       (hit_i.first_end_time),
    .second_end_time_i      (hit_i.second_end_time),
    .first_end_amplitude_i  (hit_i.first_end_amplitude),
    .second_end_amplitude_i (hit_i.second_end_amplitude),
    .start_time_i           (hit_i.start_time),
    .start_amplitude_i      (hit_i.start_amplitude),
    .valid_o                (stage_valid[0]),
    .item_o                 (stage_item[0])
  );

  // Horner steps: coefficient 2, then 1, then 0
  for (genvar s = 0; s < tofsc_pkg::HORNER_STEPS; s++) begin : g_step
    tofsc_horner_step u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv),
      .valid_i (stage_valid[s]),
      .item_i  (stage_item[s]),
      .valid_o (stage_valid[s+1]),
      .item_o  (stage_item[s+1])
    );
  end

  tofsc_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .adv_i           (adv),
    .valid_i         (stage_valid[tofsc_pkg::HORNER_STEPS]),
    .item_i          (stage_item[tofsc_pkg::HORNER_STEPS]),
    .offset_i        (offset_q),
    .valid_o         (out_valid),
    .flight_time_o   (out_time),
    .amplitude_bin_o (out_abin),
    .start_bin_o     (out_sbin)
  );

  assign res_o.valid                 = out_valid;
  assign res_o.corrected_flight_time = out_time;
  assign res_o.amplitude_bin         = out_abin;
  assign res_o.start_bin             = out_sbin;

  // a held result must freeze the input side
  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !res_o.ready) |-> !hit_i.ready)
    else $error("input taken while result is stalled");

  a_empty_after_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> !out_valid)
    else $error("result valid right after reset");

  a_bins_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (out_abin <= tofsc_pkg::ABIN_LAST &&
                   out_sbin <= tofsc_pkg::START_BIN_NONE))
    else $error("correction bin out of range");

endmodule
